### src/float_to_byte_contrast_stretch_assert.svh
// Assertion macros for the contrast stretch checker.
// Needs signals clk and arst_n in the scope where the macros are used.
`ifndef FLOAT_TO_BYTE_CONTRAST_STRETCH_ASSERT_SVH
`define FLOAT_TO_BYTE_CONTRAST_STRETCH_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ftb_pkg.sv
// Shared types and constants for the contrast stretch block.
// No dependencies; used by the controller, datapath, top level and checker.
package ftb_pkg;

	// op codes carried in s_tuser
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_GATHER = 2'd1;
	localparam logic [1:0] OP_MAP    = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_SCALE_MODE  = 2'd0;
	localparam logic [1:0] REG_MASK_ENABLE = 2'd1;
	localparam logic [1:0] REG_MASK_VALUE  = 2'd2;

	localparam int STAT_LIMIT = 99999;
	localparam int BYTE_MAX   = 255;
	localparam int DIV_STEPS  = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} ftb_state_t;

	typedef struct packed {
		logic clear;   // reset running min/max
		logic gather;  // fold sample into min/max
		logic load_x;  // capture sample for mapping
		logic setup;   // pick direct result or load divider
		logic step;    // one quotient bit
		logic emit;    // move result to output register
	} ftb_cmd_t;

	typedef struct packed {
		logic direct;  // result known without division
	} ftb_status_t;

endpackage

### src/float_to_byte_contrast_stretch.sv
// Top level of the min/max contrast stretch: APB registers, controller, datapath.
// Depends on ftb_pkg, ftb_ctrl and ftb_dpath.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  s_axis   | in  | s_tvalid/s_tready  | s_tdata: sample; s_tuser: op
//  m_axis   | out | m_tvalid/m_tready  | m_tdata: pixel_byte; m_tuser: range_empty
//  apb      | in  | psel/penable/pready| regs at 0x0, 0x4, 0x8
//
// Clear and gather words act as they are accepted. A map word runs capture, setup,
// 8 restoring-divider steps (one quotient bit each) and output load, skipping the
// steps if the result is known directly (truncate mode, empty range, clamped sample).
// Async active-low reset: running min 99999.0, max -99999.0, registers to defaults.
// A finished result sits in the output register while the next word is taken;
// a map result waits in the datapath only if the previous one is still unread.
module float_to_byte_contrast_stretch #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int FRAC_BITS    = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // [SAMPLE_WIDTH-1:0] sample
	input  logic [1:0]                            s_tuser,  // [1:0] op
	// output stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,  // [7:0] pixel_byte
	output logic                                  m_tuser,  // [0] range_empty
	// configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [3:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import ftb_pkg::*;

	logic               scale_mode_q;
	logic               mask_enable_q;
	logic signed [31:0] mask_value_q;
	logic               cfg_wr;
	ftb_cmd_t           cmd;
	ftb_status_t        status;

	// registers: written on the access cycle, decode on word index
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q  <= 1'b1;
			mask_enable_q <= 1'b0;
			mask_value_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SCALE_MODE:  scale_mode_q <= pwdata[0];
				REG_MASK_ENABLE: mask_enable_q <= pwdata[0];
				REG_MASK_VALUE:  mask_value_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SCALE_MODE:  prdata = {31'b0, scale_mode_q};
			REG_MASK_ENABLE: prdata = {31'b0, mask_enable_q};
			REG_MASK_VALUE:  prdata = mask_value_q;
			default:         prdata = '0;
		endcase
	end

	// sequencing: accept, setup, divide, hand off
	ftb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// stats, mapping arithmetic and output payload
	ftb_dpath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (signed'(s_tdata[SAMPLE_WIDTH-1:0])),
		.scale_mode  (scale_mode_q),
		.mask_enable (mask_enable_q),
		.mask_value  (mask_value_q),
		.cmd         (cmd),
		.status      (status),
		.pixel_byte  (m_tdata),
		.range_empty (m_tuser)
	);

endmodule

### src/ftb_ctrl.sv
// Controller FSM for the contrast stretch block.
// Depends on ftb_pkg; drives the datapath through ftb_cmd_t.
module ftb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic [1:0]           op,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output ftb_pkg::ftb_cmd_t    cmd,
	input  ftb_pkg::ftb_status_t status
);
	import ftb_pkg::*;

	localparam logic [2:0] DIV_LAST = 3'(DIV_STEPS - 1);

	ftb_state_t state_q, state_d;
	logic [2:0] step_q, step_d;
	logic       valid_q, valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			valid_q <= valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (op)
						OP_CLEAR:  cmd.clear = 1'b1;
						OP_GATHER: cmd.gather = 1'b1;
						OP_MAP: begin
							cmd.load_x = 1'b1;
							state_d    = ST_PREP;
						end
						default: ;
					endcase
				end
			end
			ST_PREP: begin
				cmd.setup = 1'b1;
				step_d    = '0;
				state_d   = status.direct ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				step_d   = 3'(step_q + 3'd1);
				if (step_q == DIV_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (cmd.emit) begin
			valid_d = 1'b1;
		end else if (m_tready) begin
			valid_d = 1'b0;
		end else begin
			valid_d = valid_q;
		end
	end

	assign m_tvalid = valid_q;

endmodule

### src/ftb_dpath.sv
// Datapath: running min/max, truncate path, 8-step restoring divider, output regs.
// Depends on ftb_pkg; steered by ftb_ctrl.
module ftb_dpath #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int FRAC_BITS    = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           scale_mode,
	input  logic                           mask_enable,
	input  logic signed [31:0]             mask_value,
	input  ftb_pkg::ftb_cmd_t              cmd,
	output ftb_pkg::ftb_status_t           status,
	output logic [7:0]                     pixel_byte,
	output logic                           range_empty
);
	import ftb_pkg::*;

	// stats width must hold +/-99999.0 as well as any sample
	localparam int RW = (SAMPLE_WIDTH > FRAC_BITS + 18) ? SAMPLE_WIDTH : FRAC_BITS + 18;
	localparam int CW = (SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32;
	localparam int DW = RW + 9;

	localparam logic signed [RW-1:0] STAT_HI = RW'(STAT_LIMIT) << FRAC_BITS;
	localparam logic signed [RW-1:0] STAT_LO = -STAT_HI;
	localparam logic [RW:0] ONE  = (RW+1)'(1) << FRAC_BITS;
	localparam logic [RW:0] HALF = ONE >> 1;
	localparam logic [RW:0] TOP  = (RW+1)'(BYTE_MAX) << FRAC_BITS;

	logic signed [RW-1:0] x_in, x_q, min_q, max_q;
	logic signed [CW-1:0] x_cmp, mask_cmp;
	logic                 skip;
	logic signed [RW:0]   diff, num;
	logic                 empty, below, over;
	logic [DW-1:0]        dividend, divisor;
	logic [DW-1:0]        rem_q, dsh_q;
	logic                 ge;
	logic [RW:0]          xu, tsum, tq;
	logic [7:0]           tbyte;
	logic                 direct;
	logic [7:0]           dbyte;
	logic                 dflag;
	logic [7:0]           byte_q, pixel_q;
	logic                 empty_q, flag_q;

	assign x_in     = RW'(sample);
	assign x_cmp    = CW'(sample);
	assign mask_cmp = CW'(mask_value);
	assign skip     = mask_enable && (x_cmp == mask_cmp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= STAT_HI;
			max_q <= STAT_LO;
		end else if (cmd.clear) begin
			min_q <= STAT_HI;
			max_q <= STAT_LO;
		end else if (cmd.gather && !skip) begin
			if (x_in < min_q) begin
				min_q <= x_in;
			end
			if (x_in > max_q) begin
				max_q <= x_in;
			end
		end
	end

	// min-max path
	assign diff  = (RW+1)'(max_q) - (RW+1)'(min_q);
	assign num   = (RW+1)'(x_q) - (RW+1)'(min_q);
	assign empty = (max_q <= min_q);
	assign below = (x_q < min_q);
	assign over  = (num >= diff);
	// 255*n as (n << 8) - n
	assign dividend = (DW'($unsigned(num)) << 8) - DW'($unsigned(num));
	assign divisor  = DW'($unsigned(diff)) << (DIV_STEPS - 1);

	// truncate path: clamp, then round half up
	assign xu   = $unsigned((RW+1)'(x_q));
	assign tsum = xu + HALF;
	assign tq   = tsum >> FRAC_BITS;
	always_comb begin
		if (x_q < 0) begin
			tbyte = 8'h00;
		end else if (xu > TOP || tq > (RW+1)'(BYTE_MAX)) begin
			tbyte = 8'hFF;
		end else begin
			tbyte = tq[7:0];
		end
	end

	always_comb begin
		direct = 1'b1;
		dbyte  = 8'h00;
		dflag  = 1'b0;
		if (!scale_mode) begin
			dbyte = tbyte;
		end else if (empty) begin
			dflag = 1'b1;
		end else if (below) begin
			dbyte = 8'h00;
		end else if (over) begin
			dbyte = 8'hFF;
		end else begin
			direct = 1'b0;
		end
	end

	assign status.direct = direct;
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= x_in;
		end
		if (cmd.setup) begin
			rem_q   <= dividend;
			dsh_q   <= divisor;
			byte_q  <= dbyte;
			empty_q <= dflag;
		end else if (cmd.step) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			byte_q <= {byte_q[6:0], ge};
		end
		if (cmd.emit) begin
			pixel_q <= byte_q;
			flag_q  <= empty_q;
		end
	end

	assign pixel_byte  = pixel_q;
	assign range_empty = flag_q;

endmodule

### src/ftb_checker.sv
// Port-level checks for the contrast stretch top level, bound to every instance.
// Depends on ftb_pkg and float_to_byte_contrast_stretch_assert.svh.
`include "float_to_byte_contrast_stretch_assert.svh"

module ftb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser
);
	import ftb_pkg::*;

	// stalled output word holds
	`FTB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// empty range always maps to zero
	`FTB_ASSERT_NOW(a_empty_zero, m_tvalid && m_tuser, m_tdata == 8'h00, "range_empty with nonzero byte")

	// a map word keeps the input closed while it is worked
	`FTB_ASSERT_NEXT(a_map_busy, s_tvalid && s_tready && (s_tuser == OP_MAP), !s_tready, "input open right after a map word")

	// clear and gather words never produce an output word
	`FTB_ASSERT_NEXT(a_no_spurious, s_tvalid && s_tready && (s_tuser == OP_CLEAR || s_tuser == OP_GATHER), !$rose(m_tvalid), "output word after a stats-only word")

endmodule

bind float_to_byte_contrast_stretch ftb_checker u_ftb_checker (.*);
